>>> rtl/core/page_replacement_manager_defines.svh
// Assertion macros for the page replacement manager checker.
`ifndef PAGE_REPLACEMENT_MANAGER_DEFINES_SVH
`define PAGE_REPLACEMENT_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page_replacement_manager: check failed");

// Next-cycle implication, disabled in reset.
`define PRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page_replacement_manager: check failed");

`endif

>>> rtl/core/prm_pkg.sv
// Shared constants, codes, command/status types and helpers for the page replacement manager.
package prm_pkg;

  localparam int NUM_PAGES_DEF  = 256;
  localparam int NUM_FRAMES_DEF = 64;

  localparam int PAGE_IN_W    = 8;
  localparam int FRAME_OUT_W  = 6;
  localparam int VICTIM_OUT_W = 8;
  localparam int CNT_W        = 32;
  localparam int LFSR_W       = 16;
  localparam int POLICY_W     = 2;
  localparam int FIU_W        = 7;
  localparam int ACTION_W     = 2;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_TDATA_W  = 112;

  localparam logic [POLICY_W-1:0] POL_RANDOM   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIFO     = 2'd1;
  localparam logic [POLICY_W-1:0] POL_PINGPONG = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EVICT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UPGRADE = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEED   = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIFO;
  localparam logic [FIU_W-1:0]    FIU_RESET    = 7'd64;
  localparam logic [LFSR_W-1:0]   SEED_DEFAULT = 16'd44257;
  localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
  localparam logic [CNT_W-1:0]    CNT_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic clear;
    logic accept;
    logic look;
    logic mod_step;
    logic own_rd;
    logic vic_rd;
    logic vic_clr;
    logic commit;
  } prm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pte_valid;
    logic full;
    logic random;
    logic out_free;
  } prm_stat_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ LFSR_TAPS;
    return s;
  endfunction

endpackage

>>> rtl/core/prm_ctrl.sv
// Controller state machine sequencing table clear, lookup, victim choice and commit.
module prm_ctrl import prm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  prm_stat_t stat,
  output prm_cmd_t  cmd
);

  localparam int MC_W = $clog2(LFSR_W);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_MOD, S_OWN_RD, S_OWN_WAIT, S_VIC, S_FIN
  } state_t;

  state_t            state_r;
  logic [MC_W-1:0]   mod_cnt_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state_r == S_CLEAR);
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.look     = (state_r == S_LOOK);
    cmd.mod_step = (state_r == S_MOD);
    cmd.own_rd   = (state_r == S_OWN_RD);
    cmd.vic_rd   = (state_r == S_OWN_WAIT);
    cmd.vic_clr  = (state_r == S_VIC);
    cmd.commit   = (state_r == S_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      mod_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (stat.clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) state_r <= S_LOOK;
        end
        S_LOOK: begin
          mod_cnt_r <= '0;
          if (stat.pte_valid || !stat.full) state_r <= S_FIN;
          else if (stat.random) state_r <= S_MOD;
          else state_r <= S_OWN_RD;
        end
        S_MOD: begin
          mod_cnt_r <= mod_cnt_r + 1'b1;
          if (mod_cnt_r == MC_W'(LFSR_W - 1)) state_r <= S_OWN_RD;
        end
        S_OWN_RD:   state_r <= S_OWN_WAIT;
        S_OWN_WAIT: state_r <= S_VIC;
        S_VIC:      state_r <= S_FIN;
        S_FIN: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule

>>> rtl/core/prm_dpath.sv
// Datapath: page table and frame map memories, victim pointer, LFSR, remainder unit, counters.
module prm_dpath import prm_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [PAGE_IN_W-1:0]   in_tdata,
  input  prm_cmd_t               cmd,
  output prm_stat_t              stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [ACTION_W-1:0]    out_tuser
);

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int LIM_W   = $clog2(NUM_FRAMES + 1);
  localparam int CMP_W   = (LIM_W > FIU_W) ? LIM_W : FIU_W;
  localparam int PTE_W   = FRAME_W + 2;
  localparam int RED_W   = PAGE_IN_W + 13;
  localparam int PAD_W   = OUT_TDATA_W - FRAME_OUT_W - VICTIM_OUT_W - 1 - 3 * CNT_W;

  function automatic logic [PAGE_W-1:0] reduce_page(input logic [PAGE_IN_W-1:0] v);
    logic [RED_W-1:0] r;
    r = RED_W'(v);
    for (int k = PAGE_IN_W - 1; k >= 0; k--) begin
      if (r >= (RED_W'(NUM_PAGES) << k)) r = r - (RED_W'(NUM_PAGES) << k);
    end
    return r[PAGE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // configuration
  logic [POLICY_W-1:0] policy_r;
  logic [FIU_W-1:0]    fiu_r;

  // state
  logic [LFSR_W-1:0]   lfsr_r;
  logic [LIM_W-1:0]    filled_r;
  logic [FRAME_W-1:0]  vp_r;
  logic                up_r;
  logic [CNT_W-1:0]    faults_r, loads_r, wbs_r;
  logic [PAGE_W-1:0]   clr_addr_r;

  // per-item working registers
  logic [PAGE_W-1:0]   page_r;
  logic [ACTION_W-1:0] act_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [PAGE_W-1:0]   victim_r;
  logic                wb_r;
  logic [LFSR_W-1:0]   mod_sh_r;
  logic [LIM_W-1:0]    rem_r;

  // memories
  logic [PTE_W-1:0]    pt_mem [NUM_PAGES];
  logic [PTE_W-1:0]    pt_rdata_r;
  logic [PAGE_W-1:0]   own_mem [NUM_FRAMES];
  logic [PAGE_W-1:0]   own_rdata_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [ACTION_W-1:0]    out_user_r;

  // frame limit and pointer arithmetic
  logic [CMP_W-1:0]    fiu_ext;
  logic [LIM_W-1:0]    limit, p, p_inc, fifo_next, pp_down, pp_next;
  logic                pp_flip, full, is_fifo, is_random, is_pp, loading;
  logic [LIM_W:0]      rem_sh, rem_sub;
  logic [LIM_W-1:0]    rem_nxt;
  logic [LFSR_W-1:0]   lfsr_adv;
  logic [CNT_W-1:0]    faults_nxt, loads_nxt, wbs_nxt;

  logic                pt_we, pt_re;
  logic [PAGE_W-1:0]   pt_waddr, pt_raddr;
  logic [PTE_W-1:0]    pt_wdata;
  logic [PAGE_W-1:0]   in_page;

  assign fiu_ext = CMP_W'(fiu_r);
  always_comb begin
    if (fiu_r == '0) limit = LIM_W'(1);
    else if (fiu_ext > CMP_W'(NUM_FRAMES)) limit = LIM_W'(NUM_FRAMES);
    else limit = fiu_ext[LIM_W-1:0];
  end

  assign full      = !(filled_r < limit);
  assign is_random = (policy_r == POL_RANDOM);
  assign is_pp     = (policy_r == POL_PINGPONG);
  assign is_fifo   = !is_random && !is_pp;

  assign p         = (LIM_W'(vp_r) < limit) ? LIM_W'(vp_r) : '0;
  assign p_inc     = p + 1'b1;
  assign fifo_next = (p_inc == limit) ? '0 : p_inc;
  assign pp_down   = (p == '0) ? limit - 1'b1 : p - 1'b1;
  assign pp_next   = up_r ? fifo_next : pp_down;
  assign pp_flip   = (pp_next == '0) || (pp_next == limit - 1'b1);

  // one remainder bit per step
  assign rem_sh  = {rem_r, mod_sh_r[LFSR_W-1]};
  assign rem_sub = rem_sh - {1'b0, limit};
  assign rem_nxt = (rem_sh >= {1'b0, limit}) ? rem_sub[LIM_W-1:0] : rem_sh[LIM_W-1:0];

  assign lfsr_adv = lfsr_next(lfsr_r);
  assign in_page  = reduce_page(in_tdata);
  assign loading  = (act_r == ACT_LOAD) || (act_r == ACT_EVICT);

  assign faults_nxt = loading ? sat_inc(faults_r) : faults_r;
  assign loads_nxt  = loading ? sat_inc(loads_r) : loads_r;
  assign wbs_nxt    = wb_r ? sat_inc(wbs_r) : wbs_r;

  // page table ports
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = page_r;
    pt_wdata = '0;
    if (cmd.clear) begin
      pt_we    = 1'b1;
      pt_waddr = clr_addr_r;
    end else if (cmd.vic_clr) begin
      pt_we    = 1'b1;
      pt_waddr = victim_r;
    end else if (cmd.commit && act_r == ACT_UPGRADE) begin
      pt_we    = 1'b1;
      pt_wdata = {frame_r, 1'b1, 1'b1};
    end else if (cmd.commit && loading) begin
      pt_we    = 1'b1;
      pt_wdata = {frame_r, 1'b0, 1'b1};
    end
  end

  assign pt_re    = cmd.accept || cmd.vic_rd;
  assign pt_raddr = cmd.accept ? in_page : own_rdata_r;

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rdata_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && loading) own_mem[frame_r] <= page_r;
    if (cmd.own_rd) own_rdata_r <= own_mem[frame_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_RESET;
      fiu_r       <= FIU_RESET;
      lfsr_r      <= SEED_DEFAULT;
      filled_r    <= '0;
      vp_r        <= '0;
      up_r        <= 1'b1;
      faults_r    <= '0;
      loads_r     <= '0;
      wbs_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_POLICY: policy_r <= cfg_wdata[POLICY_W-1:0];
          CFG_FRAMES: fiu_r    <= cfg_wdata[FIU_W-1:0];
          CFG_SEED:   lfsr_r   <= (cfg_wdata == '0) ? SEED_DEFAULT : cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.look && !pt_rdata_r[0]) begin
        if (!full) begin
          if (is_fifo) vp_r <= FRAME_W'(fifo_next);
        end else if (is_random) begin
          lfsr_r <= lfsr_adv;
        end else if (is_pp) begin
          vp_r <= FRAME_W'(pp_next);
          if (pp_flip) up_r <= !up_r;
        end else begin
          vp_r <= FRAME_W'(fifo_next);
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        faults_r    <= faults_nxt;
        loads_r     <= loads_nxt;
        wbs_r       <= wbs_nxt;
        if (act_r == ACT_LOAD) filled_r <= filled_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result held here while the next fault is worked on
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_user_r <= act_r;
      out_data_r <= {{PAD_W{1'b0}}, wbs_nxt, loads_nxt, faults_nxt, wb_r,
                     VICTIM_OUT_W'(victim_r), FRAME_OUT_W'(frame_r)};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) page_r <= in_page;
    if (cmd.look) begin
      victim_r <= '0;
      wb_r     <= 1'b0;
      mod_sh_r <= lfsr_adv;
      rem_r    <= '0;
      if (pt_rdata_r[0]) begin
        act_r   <= pt_rdata_r[1] ? ACT_NONE : ACT_UPGRADE;
        frame_r <= pt_rdata_r[PTE_W-1:2];
      end else if (!full) begin
        act_r   <= ACT_LOAD;
        frame_r <= FRAME_W'(filled_r);
      end else begin
        act_r   <= ACT_EVICT;
        frame_r <= FRAME_W'(p);
      end
    end
    if (cmd.mod_step) begin
      mod_sh_r <= mod_sh_r << 1;
      rem_r    <= rem_nxt;
      frame_r  <= FRAME_W'(rem_nxt);
    end
    if (cmd.vic_rd) victim_r <= own_rdata_r;
    if (cmd.vic_clr) wb_r <= pt_rdata_r[0] && pt_rdata_r[1];
  end

  assign stat.clr_last  = (clr_addr_r == PAGE_W'(NUM_PAGES - 1));
  assign stat.pte_valid = pt_rdata_r[0];
  assign stat.full      = full;
  assign stat.random    = is_random;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/page_replacement_manager.sv
// Top level of the page replacement manager: controller plus datapath.
// Each page-fault transfer yields one result transfer. After reset the page table is
// cleared one entry per cycle, NUM_PAGES entries (256 by default), with in_tready low.
// A fault then goes from lookup straight to commit when the page is resident or a
// free frame remains. When a victim is taken under fifo or ping-pong, the owner read,
// the victim's page table read and the victim clear come in between; under random the
// 16-bit LFSR value is first reduced modulo the frame count one bit per cycle.
// The page table has registered reads; a held result stalls the commit until out_tready.
// The next fault can be taken while the previous result still waits on the output.
module page_replacement_manager import prm_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PAGE_IN_W-1:0]   in_tdata,   // [7:0] page_index
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [5:0] frame_index, [13:6] victim_page, [14] write_back, [46:15] fault_count,
  // [78:47] read_count, [110:79] write_count, [111] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [ACTION_W-1:0]    out_tuser   // [1:0] action
);

  prm_cmd_t  cmd;
  prm_stat_t stat;

  prm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prm_dpath #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/prm_checker.sv
// Port-level checker for the page replacement manager, with its bind.
`include "page_replacement_manager_defines.svh"

module prm_checker import prm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [ACTION_W-1:0]    out_tuser
);

  `PRM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `PRM_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `PRM_ASSERT_NOW(a_loads_eq_faults, out_tvalid, out_tdata[46:15] == out_tdata[78:47])
  `PRM_ASSERT_NOW(a_wb_on_evict, out_tvalid && out_tdata[14], out_tuser == ACT_EVICT)
  `PRM_ASSERT_NOW(a_victim_zero, out_tvalid && (out_tuser != ACT_EVICT), out_tdata[13:6] == '0)

endmodule

bind page_replacement_manager prm_checker u_prm_checker (.*);
